// ===== src/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Beat types, operation codes and the fixed constants of the SHA-1 rounds.
// ----------------------------------------------------------------------------
package sha1_pkg;

	typedef logic [4:0][31:0] word5_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
		logic        error;
	} out_item_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam word5_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'd4;
	localparam logic [6:0] LAST_RND = 7'd79;

endpackage

// ===== src/sha1_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Runs the 80 compression rounds of one 512-bit block, one round per cycle,
// with a rolling 16-word message schedule.
// ----------------------------------------------------------------------------
module sha1_core
	import sha1_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [511:0] block,
	input  word5_t       chain,
	output logic         done,
	output word5_t       work
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] win_q [16];

	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] mix;
	logic [31:0] w_new;
	logic [31:0] t_sum;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_3;
		end
		mix   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		w_new = {mix[30:0], mix[31]};
		t_sum = {a_q[26:0], a_q[31:27]} + f_val + e_q + win_q[0] + k_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == LAST_RND) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= chain[0];
			b_q <= chain[1];
			c_q <= chain[2];
			d_q <= chain[3];
			e_q <= chain[4];
			for (int i = 0; i < 16; i++) begin
				win_q[i] <= block[511 - 32 * i -: 32];
			end
		end else if (busy_q) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
		end
	end

	assign done = done_q;
	assign work = {e_q, d_q, c_q, b_q, a_q};

endmodule

// ===== src/sha1_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Takes message bytes one beat at a time and returns the SHA-1 digest as five
// 32-bit words on a finish beat.
//
// The byte channel carries an operation and a byte: absorb adds the byte to
// the message, finish pads the message and emits the digest. The digest
// channel returns words 0 to 4, most significant first, last set on word 4.
// If the message exceeds 2^64 - 1 bits, finish returns a single beat with
// error and last set and a zero word.
// An absorb beat that completes a 64-byte block holds the byte channel
// stalled while the round unit compresses the block, one round per cycle.
// Finish pads the message one byte per cycle, pausing for each of the one or
// two block compressions, then emits the digest words in order.
// byte_stall is high while a block is compressed, padded or emitted.
// A stalled digest beat holds in the output register; emission waits.
// After reset and after every finish the engine starts a new message from
// the initial chaining values.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit
	import sha1_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_beat,
	output logic      digest_valid,
	input  logic      digest_stall,
	output out_item_t digest_beat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PADZ,
		ST_PADLEN,
		ST_HASH,
		ST_EMIT
	} state_t;

	state_t       state_q;
	state_t       ret_q;
	word5_t       chain_q;
	logic [511:0] buf_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [63:0]  len_q;
	logic         too_long_q;
	logic         start_q;
	logic [2:0]   idx_q;
	logic         out_valid_q;
	out_item_t    out_q;

	logic         accept;
	logic         push;
	logic [7:0]   push_byte;
	logic         full;
	logic [63:0]  bits_next;
	logic         load_ok;
	logic         core_done;
	word5_t       core_work;

	sha1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.block  (buf_q),
		.chain  (chain_q),
		.done   (core_done),
		.work   (core_work)
	);

	assign byte_stall = (state_q != ST_IDLE);
	assign accept     = byte_valid && (state_q == ST_IDLE);
	assign bits_next  = bits_q + 64'd8;
	assign load_ok    = !out_valid_q || !digest_stall;

	always_comb begin
		push      = 1'b0;
		push_byte = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && !too_long_q) begin
					push      = 1'b1;
					push_byte = (byte_beat.op == OP_ABSORB) ? byte_beat.data_byte : PAD_BYTE;
				end
			end
			ST_PADZ: begin
				push = (fill_q != LEN_POS);
			end
			ST_PADLEN: begin
				push      = 1'b1;
				push_byte = len_q[63:56];
			end
			default: begin
				push = 1'b0;
			end
		endcase
		full = push && (fill_q == LAST_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			chain_q     <= H_INIT;
			fill_q      <= '0;
			bits_q      <= '0;
			too_long_q  <= 1'b0;
			start_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !digest_stall) begin
				out_valid_q <= 1'b0;
			end
			if (push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (full) begin
				start_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (byte_beat.op == OP_ABSORB) begin
							if (!too_long_q) begin
								bits_q <= bits_next;
								if (bits_next == 64'd0) begin
									too_long_q <= 1'b1;
								end
								if (full) begin
									state_q <= ST_HASH;
									ret_q   <= ST_IDLE;
								end
							end
						end else begin
							idx_q <= '0;
							if (too_long_q) begin
								state_q <= ST_EMIT;
							end else if (full) begin
								state_q <= ST_HASH;
								ret_q   <= ST_PADZ;
							end else begin
								state_q <= ST_PADZ;
							end
						end
					end
				end
				ST_PADZ: begin
					if (fill_q == LEN_POS) begin
						state_q <= ST_PADLEN;
					end else if (full) begin
						state_q <= ST_HASH;
						ret_q   <= ST_PADZ;
					end
				end
				ST_PADLEN: begin
					if (full) begin
						state_q <= ST_HASH;
						ret_q   <= ST_EMIT;
					end
				end
				ST_HASH: begin
					if (core_done) begin
						for (int i = 0; i < 5; i++) begin
							chain_q[i] <= chain_q[i] + core_work[i];
						end
						state_q <= ret_q;
					end
				end
				ST_EMIT: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						if (too_long_q || idx_q == LAST_IDX) begin
							chain_q    <= H_INIT;
							fill_q     <= '0;
							bits_q     <= '0;
							too_long_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q <= {buf_q[503:0], push_byte};
		end
		if (state_q == ST_IDLE) begin
			len_q <= bits_q;
		end else if (push && state_q == ST_PADLEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (state_q == ST_EMIT && load_ok) begin
			if (too_long_q) begin
				out_q.digest_word <= '0;
				out_q.word_index  <= '0;
				out_q.last        <= 1'b1;
				out_q.error       <= 1'b1;
			end else begin
				out_q.digest_word <= chain_q[idx_q];
				out_q.word_index  <= idx_q;
				out_q.last        <= (idx_q == LAST_IDX);
				out_q.error       <= 1'b0;
			end
		end
	end

	assign digest_valid = out_valid_q;
	assign digest_beat  = out_q;

endmodule
